@@ rtl/core/mvrf_pkg.sv @@
// Shared types and constants for the version row filter.
package mvrf_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned ROW_KEY_W  = 64;
  localparam int unsigned ROW_VER_W  = 64;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned OUT_CNT_W  = 32;
  localparam int unsigned FLAG_NUM   = 4;
  localparam int unsigned S_TDATA_W  = ROW_KEY_W + ROW_VER_W;
  localparam int unsigned M_TDATA_RAW_W = FLAG_NUM + 5 * OUT_CNT_W;
  localparam int unsigned M_TDATA_W  = ((M_TDATA_RAW_W + 7) / 8) * 8;

  // Parameter defaults
  localparam int unsigned KEY_WIDTH_DEF   = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Decision queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    MODE_MVCC    = 1'b0,
    MODE_COMPACT = 1'b1
  } filter_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE   = 1'b0,
    CFG_VERSION_LIMIT = 1'b1
  } cfg_idx_e;

  // Outcome of one row decision
  typedef struct packed {
    logic keep;
    logic eff;
    logic nc;
    logic del;
    logic last;
  } rec_t;

endpackage

@@ rtl/core/mvcc_version_row_filter.sv @@
// Version row filter: top level with configuration registers and stream ports.
//
// Rows sorted by key then version enter on the slave stream (tdata holds key and
// version, tuser the delete mark, tlast the end of stream). The filter holds one
// row back and decides it when the next row arrives, under MVCC or COMPACT rules
// against the version limit; the final row of a stream is decided on its own, so
// a final row after a held row yields two results. Each result carries keep and
// the COMPACT flags plus running saturating counters (cleared by reset only). The
// block takes one row per cycle while the queue has room and nothing is pending;
// a final row after a held row holds the input off while its second result is
// pushed. A two-entry decision queue separates classification from counting.
// Write configuration only while no item is in flight.
module mvcc_version_row_filter import mvrf_pkg::*; #(
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Row input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // row_key[63:0], row_version[127:64]
  input  logic                  s_axis_tuser,  // delete_mark
  input  logic                  s_axis_tlast,  // end_of_stream
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // row_keep[0], row_effective[1], row_not_clean[2], row_deleted[3],
  // rows_seen[35:4], rows_kept[67:36], not_clean_total[99:68],
  // deleted_total[131:100], effective_total[163:132], zero pad above
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast   // last_result
);

  filter_mode_e         mode_q;
  logic [ROW_VER_W-1:0] limit_q;
  logic                 cfg_write;

  logic push_valid, push_ready, pop_valid, pop_ready;
  rec_t push_rec, pop_rec;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_MVCC;
      limit_q <= '1;
    end else if (cfg_write) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FILTER_MODE:   mode_q  <= filter_mode_e'(cfg_data_i[0]);
        CFG_VERSION_LIMIT: limit_q <= cfg_data_i[ROW_VER_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify: hold one row, decide the previous one
  mvrf_front #(
    .KeyWidth(KEY_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .limit_i        (limit_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .row_key_i      (s_axis_tdata[ROW_KEY_W-1:0]),
    .row_version_i  (s_axis_tdata[S_TDATA_W-1:ROW_KEY_W]),
    .delete_mark_i  (s_axis_tuser),
    .end_of_stream_i(s_axis_tlast),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_rec_o     (push_rec)
  );

  // Decouple classification from counting
  mvrf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_rec_i  (push_rec),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_rec_o   (pop_rec)
  );

  // Count and present one result per cycle while the result stream is not stalled
  mvrf_back #(
    .CountWidth(COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(pop_valid),
    .rec_ready_o(pop_ready),
    .rec_i      (pop_rec),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

endmodule

@@ rtl/core/mvrf_front.sv @@
// Front end: accepts rows, holds one row back and classifies the held row.
module mvrf_front import mvrf_pkg::*; #(
  parameter int unsigned KeyWidth = KEY_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  filter_mode_e         mode_i,
  input  logic [ROW_VER_W-1:0] limit_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ROW_KEY_W-1:0] row_key_i,
  input  logic [ROW_VER_W-1:0] row_version_i,
  input  logic                 delete_mark_i,
  input  logic                 end_of_stream_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output rec_t                 push_rec_o
);

  logic                 held_valid_q, held_valid_d;
  logic [KeyWidth-1:0]  held_key_q;
  logic [ROW_VER_W-1:0] held_ver_q;
  logic                 held_del_q;
  logic                 pend_q, pend_d;
  rec_t                 pend_rec_q, pend_rec_d;

  logic accept;
  logic diff_key, next_above, held_le, held_ge, in_le, in_ge;
  rec_t pair_rec, last_rec;

  assign in_ready_o = !pend_q && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign diff_key   = held_key_q != row_key_i[KeyWidth-1:0];
  assign next_above = row_version_i > limit_i;
  assign held_le    = held_ver_q <= limit_i;
  assign held_ge    = held_ver_q >= limit_i;
  assign in_le      = row_version_i <= limit_i;
  assign in_ge      = row_version_i >= limit_i;

  // Held row decided against the incoming row
  always_comb begin
    pair_rec = '0;
    unique case (mode_i)
      MODE_MVCC: begin
        pair_rec.keep = !held_del_q && held_le && (diff_key || next_above);
      end
      MODE_COMPACT: begin
        pair_rec.keep = held_ge || ((diff_key || next_above) && !held_del_q);
        pair_rec.nc   = pair_rec.keep && (!diff_key || held_del_q);
        pair_rec.eff  = pair_rec.keep && diff_key;
        pair_rec.del  = pair_rec.keep && held_del_q;
      end
      default: pair_rec = '0;
    endcase
  end

  // Final row of a stream, decided with no next row
  always_comb begin
    last_rec      = '0;
    last_rec.last = 1'b1;
    unique case (mode_i)
      MODE_MVCC: begin
        last_rec.keep = !delete_mark_i && in_le;
      end
      MODE_COMPACT: begin
        last_rec.keep = in_ge || !delete_mark_i;
        last_rec.nc   = last_rec.keep && delete_mark_i;
        last_rec.eff  = last_rec.keep;
        last_rec.del  = last_rec.keep && delete_mark_i;
      end
      default: last_rec.keep = 1'b0;
    endcase
  end

  always_comb begin
    push_valid_o = 1'b0;
    push_rec_o   = pair_rec;
    pend_d       = pend_q;
    pend_rec_d   = pend_rec_q;
    held_valid_d = held_valid_q;
    if (pend_q) begin
      push_valid_o = 1'b1;
      push_rec_o   = pend_rec_q;
      if (push_ready_i) begin
        pend_d = 1'b0;
      end
    end else if (accept) begin
      held_valid_d = !end_of_stream_i;
      if (held_valid_q) begin
        push_valid_o = 1'b1;
        push_rec_o   = pair_rec;
        if (end_of_stream_i) begin
          // Second result of this item waits in the pending register until the queue takes it
          pend_d     = 1'b1;
          pend_rec_d = last_rec;
        end
      end else if (end_of_stream_i) begin
        push_valid_o = 1'b1;
        push_rec_o   = last_rec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_rec_q <= pend_rec_d;
    if (accept) begin
      held_key_q <= row_key_i[KeyWidth-1:0];
      held_ver_q <= row_version_i;
      held_del_q <= delete_mark_i;
    end
  end

endmodule

@@ rtl/core/mvrf_queue.sv @@
// Short decision queue between the front and back ends.
module mvrf_queue import mvrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  rec_t push_rec_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output rec_t pop_rec_o
);

  rec_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_rec_o    = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_rec_i;
    end
  end

endmodule

@@ rtl/core/mvrf_back.sv @@
// Back end: counts decisions and holds the result in the output register.
module mvrf_back import mvrf_pkg::*; #(
  parameter int unsigned CountWidth = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rec_valid_i,
  output logic                 rec_ready_o,
  input  rec_t                 rec_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [M_TDATA_W-1:0] m_data_o,
  output logic                 m_last_o
);

  logic [CountWidth-1:0] cnt_seen_q, cnt_seen_d;
  logic [CountWidth-1:0] cnt_kept_q, cnt_kept_d;
  logic [CountWidth-1:0] cnt_nc_q, cnt_nc_d;
  logic [CountWidth-1:0] cnt_del_q, cnt_del_d;
  logic [CountWidth-1:0] cnt_eff_q, cnt_eff_d;
  logic                  out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0]  out_data_q, out_data_d;
  logic                  out_last_q;
  logic                  load;

  function automatic logic [CountWidth-1:0] sat_inc(logic [CountWidth-1:0] c, logic hit);
    logic [CountWidth-1:0] r;
    r = c;
    if (hit && c != '1) begin
      r = c + 1'b1;
    end
    return r;
  endfunction

  // Load a new result when the register is empty or being drained
  assign load        = rec_valid_i && (!out_valid_q || m_ready_i);
  assign rec_ready_o = load;

  assign cnt_seen_d = sat_inc(cnt_seen_q, 1'b1);
  assign cnt_kept_d = sat_inc(cnt_kept_q, rec_i.keep);
  assign cnt_nc_d   = sat_inc(cnt_nc_q, rec_i.nc);
  assign cnt_del_d  = sat_inc(cnt_del_q, rec_i.del);
  assign cnt_eff_d  = sat_inc(cnt_eff_q, rec_i.eff);

  assign out_data_d = M_TDATA_W'({OUT_CNT_W'(cnt_eff_d), OUT_CNT_W'(cnt_del_d),
                                  OUT_CNT_W'(cnt_nc_d), OUT_CNT_W'(cnt_kept_d),
                                  OUT_CNT_W'(cnt_seen_d),
                                  rec_i.del, rec_i.nc, rec_i.eff, rec_i.keep});

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_seen_q  <= '0;
      cnt_kept_q  <= '0;
      cnt_nc_q    <= '0;
      cnt_del_q   <= '0;
      cnt_eff_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        cnt_seen_q <= cnt_seen_d;
        cnt_kept_q <= cnt_kept_d;
        cnt_nc_q   <= cnt_nc_d;
        cnt_del_q  <= cnt_del_d;
        cnt_eff_q  <= cnt_eff_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
      out_last_q <= rec_i.last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

  a_seen_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> cnt_seen_q != '0)
    else $error("row count zero after a decision");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(cnt_seen_q) && $stable(cnt_kept_q) && $stable(cnt_eff_q))
    else $error("counters moved without a decision");

  a_kept_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !rec_i.keep) |=> $stable(cnt_kept_q))
    else $error("kept count moved on a dropped row");

  a_nc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !rec_i.nc) |=> $stable(cnt_nc_q))
    else $error("not-clean count moved on a clean row");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the version row filter: directed rows, random streams.
module tb import mvrf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // One input row as the stream carries it
  typedef struct packed {
    logic [ROW_KEY_W-1:0] key;
    logic [ROW_VER_W-1:0] ver;
    logic                 del;
    logic                 eos;
  } row_t;

  // One predicted row decision, counters after it is counted
  typedef struct packed {
    logic                 keep;
    logic                 eff;
    logic                 nc;
    logic                 del;
    logic                 last;
    logic [OUT_CNT_W-1:0] seen;
    logic [OUT_CNT_W-1:0] kept;
    logic [OUT_CNT_W-1:0] nc_total;
    logic [OUT_CNT_W-1:0] del_total;
    logic [OUT_CNT_W-1:0] eff_total;
  } verdict_t;

  localparam int unsigned TALLY_W = COUNT_WIDTH_DEF;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;  // row_key[63:0], row_version[127:64]
  logic                  s_axis_tuser;  // delete_mark
  logic                  s_axis_tlast;  // end_of_stream
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // row_keep[0], row_effective[1], row_not_clean[2], row_deleted[3],
  // rows_seen[35:4], rows_kept[67:36], not_clean_total[99:68],
  // deleted_total[131:100], effective_total[163:132], zero pad above
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;  // last_result

  mvcc_version_row_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // Filter predictor: its own copy of the registers, the held row and tallies
  // ---------------------------------------------------------------------------
  filter_mode_e         mode_now;
  logic [63:0]          limit_now;
  bit                   held_ok;
  logic [ROW_KEY_W-1:0] held_key;
  logic [ROW_VER_W-1:0] held_ver;
  bit                   held_del;
  logic [TALLY_W-1:0]   tally_seen, tally_kept, tally_nc, tally_del, tally_eff;

  // Decisions still owed by the block, oldest first
  verdict_t verdict_q[$];

  int unsigned mismatches;
  bit          src_calm;  // sender never idles while set
  bit          snk_calm;  // receiver never stalls while set

  // Saturating increment: stop at all ones
  function automatic logic [TALLY_W-1:0] tally_up(logic [TALLY_W-1:0] c, bit hit);
    return (hit && c != {TALLY_W{1'b1}}) ? c + 1'b1 : c;
  endfunction

  // Decide one row; without a next row the last-row rule applies
  function automatic void judge_row(logic [ROW_KEY_W-1:0] key, logic [ROW_VER_W-1:0] ver,
                                    bit del, bit has_next, logic [ROW_KEY_W-1:0] nkey,
                                    logic [ROW_VER_W-1:0] nver, bit last);
    bit       keep, eff, nc, isdel, diff_key, next_above;
    verdict_t v;
    eff        = 1'b0;
    nc         = 1'b0;
    isdel      = 1'b0;
    diff_key   = (key != nkey);
    next_above = (nver > limit_now);
    if (mode_now == MODE_MVCC) begin
      // MVCC leaves the three extra flags at zero
      keep = !del && ver <= limit_now && (!has_next || diff_key || next_above);
    end else begin
      if (has_next) begin
        keep = ver >= limit_now || ((diff_key || next_above) && !del);
        nc   = keep && (!diff_key || del);
        eff  = keep && diff_key;
      end else begin
        keep = ver >= limit_now || !del;
        nc   = keep && del;
        eff  = keep;
      end
      isdel = keep && del;
    end
    tally_seen = tally_up(tally_seen, 1'b1);
    tally_kept = tally_up(tally_kept, keep);
    tally_nc   = tally_up(tally_nc, nc);
    tally_del  = tally_up(tally_del, isdel);
    tally_eff  = tally_up(tally_eff, eff);
    v.keep      = keep;
    v.eff       = eff;
    v.nc        = nc;
    v.del       = isdel;
    v.last      = last;
    v.seen      = tally_seen[OUT_CNT_W-1:0];
    v.kept      = tally_kept[OUT_CNT_W-1:0];
    v.nc_total  = tally_nc[OUT_CNT_W-1:0];
    v.del_total = tally_del[OUT_CNT_W-1:0];
    v.eff_total = tally_eff[OUT_CNT_W-1:0];
    verdict_q.push_back(v);
  endfunction

  // Account for one accepted row: decide the held row, then hold or close out
  function automatic void take_row(row_t r);
    if (held_ok)
      judge_row(held_key, held_ver, held_del, 1'b1, r.key, r.ver, 1'b0);
    if (r.eos) begin
      judge_row(r.key, r.ver, r.del, 1'b0, '0, '0, 1'b1);
      held_ok = 1'b0;
    end else begin
      held_ok  = 1'b1;
      held_key = r.key;
      held_ver = r.ver;
      held_del = r.del;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic row_t mk_row(logic [63:0] key, logic [63:0] ver, bit del, bit eos);
    row_t r;
    r.key = key;
    r.ver = ver;
    r.del = del;
    r.eos = eos;
    return r;
  endfunction

  // Versions clustered around the limit so both sides of each compare show up
  function automatic logic [63:0] near_limit();
    case ($urandom_range(0, 4))
      0:       return {$urandom, $urandom};
      1:       return limit_now;
      2:       return limit_now - $urandom_range(1, 4);
      3:       return limit_now + $urandom_range(1, 4);
      default: return limit_now - $urandom_range(0, 8);
    endcase
  endfunction

  // Send one item. Valid stays high on return so a back-to-back item needs
  // no second assignment in the same step; drain_results lowers it.
  task automatic push_row(row_t r);
    int unsigned gap;
    gap = pick_gap(src_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.ver, r.key};
    s_axis_tuser  <= r.del;
    s_axis_tlast  <= r.eos;
    do @(posedge clk_i); while (!s_axis_tready);
    take_row(r);
  endtask

  // Hold the sender off until every owed result has arrived, then settle
  task automatic drain_results(int unsigned settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FILTER_MODE)
      mode_now = filter_mode_e'(data[0]);
    else
      limit_now = data;
  endtask

  // Reconfigure only once the block is quiet; a held row may remain
  task automatic set_filter(filter_mode_e mode, logic [63:0] limit);
    logic [CFG_DATA_W-1:0] mode_word;
    drain_results(4);
    // Junk in the upper bits of the mode word must be ignored
    mode_word    = {$urandom, $urandom};
    mode_word[0] = mode;
    write_reg(CFG_FILTER_MODE, mode_word);
    write_reg(CFG_VERSION_LIMIT, limit);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers untouched: MVCC with the limit at all ones
  task automatic test_reset_defaults();
    push_row(mk_row('0, '0, 1'b0, 1'b0));
    push_row(mk_row('0, '1, 1'b0, 1'b0));
    push_row(mk_row('1, '1, 1'b1, 1'b1));
  endtask

  // Final row with nothing held is decided on its own
  task automatic test_lone_final_row();
    push_row(mk_row(64'h0123_4567_89ab_cdef, '0, 1'b0, 1'b1));
    set_filter(MODE_COMPACT, '0);
    push_row(mk_row(64'h5, '1, 1'b1, 1'b1));
    set_filter(MODE_COMPACT, '1);
    push_row(mk_row(64'h5, 64'd5, 1'b1, 1'b1));
    push_row(mk_row(64'h5, 64'd5, 1'b0, 1'b1));
  endtask

  task automatic test_mvcc_rules();
    set_filter(MODE_MVCC, 64'd100);
    push_row(mk_row(64'd5, 64'd50, 1'b0, 1'b0));
    push_row(mk_row(64'd5, 64'd99, 1'b0, 1'b0));   // shadows the row before
    push_row(mk_row(64'd5, 64'd101, 1'b0, 1'b0));  // above the limit
    push_row(mk_row(64'd6, 64'd100, 1'b1, 1'b0));  // delete marker at the limit
    push_row(mk_row(64'd7, 64'd100, 1'b0, 1'b0));
    // keys differ only in the top bit
    push_row(mk_row(64'h8000_0000_0000_0007, 64'd0, 1'b0, 1'b0));
    push_row(mk_row(64'h8000_0000_0000_0007, 64'd100, 1'b0, 1'b1));
  endtask

  task automatic test_compact_rules();
    set_filter(MODE_COMPACT, 64'd100);
    push_row(mk_row(64'd5, 64'd100, 1'b1, 1'b0));
    push_row(mk_row(64'd5, 64'd150, 1'b1, 1'b0));
    push_row(mk_row(64'h8000_0000_0000_0005, 64'd20, 1'b1, 1'b0));
    push_row(mk_row(64'h8000_0000_0000_0005, 64'd30, 1'b0, 1'b0));
    push_row(mk_row(64'h8000_0000_0000_0006, 64'd99, 1'b1, 1'b1));
  endtask

  // A held row is decided under the mode in force when the next row lands
  task automatic test_mode_switch_on_held_row();
    set_filter(MODE_MVCC, 64'd100);
    push_row(mk_row(64'd9, 64'd100, 1'b1, 1'b0));
    set_filter(MODE_COMPACT, 64'd100);
    push_row(mk_row(64'd9, 64'd100, 1'b0, 1'b1));
    push_row(mk_row(64'd10, 64'd40, 1'b0, 1'b0));
    set_filter(MODE_MVCC, 64'd30);
    push_row(mk_row(64'd11, 64'd20, 1'b0, 1'b1));
  endtask

  // Sorted run with random content; sometimes left open so the next run
  // joins it unsorted
  task automatic send_sorted_stream(inout int unsigned sent);
    int unsigned len;
    logic [63:0] key, ver;
    len = $urandom_range(1, 10);
    key = {$urandom, $urandom};
    ver = near_limit();
    for (int i = 0; i < len; i++) begin
      if (i != 0) begin
        if ($urandom_range(0, 2) == 0) begin
          key = key + $urandom_range(1, 3);
          ver = near_limit();
        end else begin
          ver = ver + $urandom_range(1, 2);
        end
      end
      push_row(mk_row(key, ver, $urandom_range(0, 3) == 0,
                      (i == len - 1) && ($urandom_range(0, 7) != 0)));
      sent++;
    end
  endtask

  task automatic test_random_streams();
    int unsigned sent;
    logic [63:0] limit;
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0:       limit = '0;
        1:       limit = '1;
        2:       limit = {$urandom, $urandom};
        default: limit = $urandom_range(0, 50);
      endcase
      set_filter(filter_mode_e'(ph % 2), limit);
      src_calm = ($urandom_range(0, 3) == 0);
      snk_calm = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 100) begin
        case ($urandom_range(0, 9))
          8: begin
            // noise: unrelated row
            push_row(mk_row({$urandom, $urandom},
                            $urandom_range(0, 1) ? {$urandom, $urandom} : near_limit(),
                            $urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0));
            sent++;
          end
          9:       drain_results(0);  // pause until the block has caught up
          default: send_sorted_stream(sent);
        endcase
      end
    end
    src_calm = 1'b0;
    snk_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : run_tests
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_FILTER_MODE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    mode_now   = MODE_MVCC;
    limit_now  = '1;
    held_ok    = 1'b0;
    held_key   = '0;
    held_ver   = '0;
    held_del   = 1'b0;
    tally_seen = '0;
    tally_kept = '0;
    tally_nc   = '0;
    tally_del  = '0;
    tally_eff  = '0;
    mismatches = 0;
    src_calm   = 1'b0;
    snk_calm   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_lone_final_row();
    test_mvcc_rules();
    test_compact_rules();
    test_mode_switch_on_held_row();
    test_random_streams();

    drain_results(8);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, compare each accepted item with the oldest
  // prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_monitor
    int unsigned          stall;
    verdict_t             want;
    logic [M_TDATA_W-1:0] got;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = pick_gap(snk_calm);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata;
      if (verdict_q.size() == 0) begin
        $error("result item arrived with no decision pending");
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("row_keep", 32'(want.keep), 32'(got[0]));
        check_field("row_effective", 32'(want.eff), 32'(got[1]));
        check_field("row_not_clean", 32'(want.nc), 32'(got[2]));
        check_field("row_deleted", 32'(want.del), 32'(got[3]));
        check_field("last_result", 32'(want.last), 32'(m_axis_tlast));
        check_field("rows_seen", want.seen, got[35:4]);
        check_field("rows_kept", want.kept, got[67:36]);
        check_field("not_clean_total", want.nc_total, got[99:68]);
        check_field("deleted_total", want.del_total, got[131:100]);
        check_field("effective_total", want.eff_total, got[163:132]);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ mvcc_version_row_filter.f @@
rtl/core/mvrf_pkg.sv
rtl/core/mvrf_front.sv
rtl/core/mvrf_queue.sv
rtl/core/mvrf_back.sv
rtl/core/mvcc_version_row_filter.sv
bench/tb.sv
